@@ sv/oepg_pkg.sv @@
// ----------------------------------------------------------------------------
// oepg_pkg
// Shared types, constants and helper functions for the orbit point generator.
// ----------------------------------------------------------------------------
package oepg_pkg;

    typedef enum logic [2:0] {
        CFG_SEMI_MAJOR = 3'd0,
        CFG_ECC        = 3'd1,
        CFG_INCL       = 3'd2,
        CFG_RES        = 3'd3
    } cfg_idx_t;

    localparam int CORDIC_STEPS = 16;
    localparam logic [15:0] ECC_MAX = 16'd64880;
    localparam logic [9:0]  RES_MIN = 10'd32;
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } cordic_t;

    typedef struct packed {
        logic signed [17:0] c;
        logic signed [17:0] s;
    } cs_t;

    // quadrant fold and start vector for a phase in turns
    function automatic cordic_t cordic_prep(input logic [15:0] phase);
        cordic_t r;
        logic [15:0] shifted;
        logic signed [14:0] rem;
        shifted = phase + 16'd8192;
        rem     = $signed({1'b0, shifted[13:0]}) - 15'sd8192;
        r.x     = CORDIC_X0;
        r.y     = '0;
        r.z     = 32'(rem) <<< 16;
        r.quad  = shifted[15:14];
        return r;
    endfunction

    function automatic logic signed [17:0] clamp_unit(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v > 19'sd65536) begin
            r = 18'sd65536;
        end else if (v < -19'sd65536) begin
            r = -18'sd65536;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    function automatic cs_t cordic_post(input cordic_t v);
        cs_t r;
        logic signed [32:0] cx;
        logic signed [32:0] sy;
        logic signed [18:0] c;
        logic signed [18:0] s;
        cx = (v.x + 33'sd8192) >>> 14;
        sy = (v.y + 33'sd8192) >>> 14;
        c  = cx[18:0];
        s  = sy[18:0];
        unique case (v.quad)
            2'd0: begin
                r.c = clamp_unit(c);
                r.s = clamp_unit(s);
            end
            2'd1: begin
                r.c = clamp_unit(-s);
                r.s = clamp_unit(c);
            end
            2'd2: begin
                r.c = clamp_unit(-c);
                r.s = clamp_unit(-s);
            end
            default: begin
                r.c = clamp_unit(s);
                r.s = clamp_unit(-c);
            end
        endcase
        return r;
    endfunction

    function automatic logic [21:0] sat_out(input logic signed [66:0] v);
        logic [21:0] r;
        if (v > 67'sd2097151) begin
            r = 22'h1FFFFF;
        end else if (v < -67'sd2097152) begin
            r = 22'h200000;
        end else begin
            r = v[21:0];
        end
        return r;
    endfunction

endpackage

@@ sv/oepg_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// oepg_cordic_cell
// One registered CORDIC rotation step, fixed shift and angle per position.
// ----------------------------------------------------------------------------
module oepg_cordic_cell
    import oepg_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    cordic_t data_reg;
    cordic_t data_next;

    always_comb begin
        data_next      = din;
        if (din.z >= 0) begin
            data_next.x = din.x - (din.y >>> STEP);
            data_next.y = din.y + (din.x >>> STEP);
            data_next.z = din.z - ATAN_TURN[STEP];
        end else begin
            data_next.x = din.x + (din.y >>> STEP);
            data_next.y = din.y - (din.x >>> STEP);
            data_next.z = din.z + ATAN_TURN[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

@@ sv/oepg_div_cell.sv @@
// ----------------------------------------------------------------------------
// oepg_div_cell
// One registered restoring division step, one quotient bit per cell.
// ----------------------------------------------------------------------------
module oepg_div_cell
    import oepg_pkg::*;
#(
    parameter int DW = 10,
    parameter int LW = 21,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [LW-1:0] low_in,
    input  logic [QW-1:0] quo_in,
    input  logic [DW-1:0] dvs_in,
    output logic [DW-1:0] rem_out,
    output logic [LW-1:0] low_out,
    output logic [QW-1:0] quo_out,
    output logic [DW-1:0] dvs_out
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [LW-1:0] low_reg, low_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        trial    = {rem_in, low_in[LW-1]};
        diff     = trial - {1'b0, dvs_in};
        ge       = (trial >= {1'b0, dvs_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        low_next = {low_in[LW-2:0], 1'b0};
        quo_next = {quo_in[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_in;
        end
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;
    assign dvs_out = dvs_reg;

endmodule

@@ sv/orbit_ellipse_point_generator_top.sv @@
// ----------------------------------------------------------------------------
// orbit_ellipse_point_generator_top
// Orbit point generator: phase divider, CORDIC rows, radius divider, rotation.
//
//   channel   dir   payload                              handshake
//   s_        in    point_index                          tvalid/tready
//   m_        out   pos_x, pos_y, pos_z, tlast=closing   tvalid/tready
//   cfg_      in    register index, write data           wr_en only
//
// one transaction per cycle while results are accepted, passing through the rows of
// divider and CORDIC cells (21 phase steps, 16 rotations, 29 radius steps)
// the whole row advances together; it holds while a result waits unaccepted
// synchronous active-low reset loads configuration defaults and clears the valid and closing-flag lines only
// ----------------------------------------------------------------------------
module orbit_ellipse_point_generator_top
    import oepg_pkg::*;
#(
    parameter int MAX_RESOLUTION = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // point_index[9:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // pos_x[21:0], pos_y[43:22], pos_z[65:44], pad
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wdata
);

    localparam int D1_STEPS = 21;
    localparam int D2_STEPS = 29;
    localparam int CS_DLY   = D2_STEPS + 2;
    localparam int LAT      = 1 + D1_STEPS + 1 + CORDIC_STEPS + 1 + 2 + D2_STEPS + 3;

    // configuration
    logic [19:0]        sma_reg, sma_next;
    logic [15:0]        ecc_reg, ecc_next;
    logic signed [16:0] inc_reg, inc_next;
    logic [9:0]         res_reg, res_next;

    always_comb begin
        sma_next = sma_reg;
        ecc_next = ecc_reg;
        inc_next = inc_reg;
        res_next = res_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SEMI_MAJOR: sma_next = cfg_wdata;
                CFG_ECC: begin
                    ecc_next = (cfg_wdata[15:0] > ECC_MAX) ? ECC_MAX : cfg_wdata[15:0];
                end
                CFG_INCL: inc_next = $signed(cfg_wdata[16:0]);
                CFG_RES: begin
                    if (cfg_wdata[9:0] < RES_MIN) begin
                        res_next = RES_MIN;
                    end else if (32'(cfg_wdata[9:0]) > MAX_RESOLUTION) begin
                        res_next = 10'(MAX_RESOLUTION);
                    end else begin
                        res_next = cfg_wdata[9:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sma_reg <= 20'd256;
            ecc_reg <= '0;
            inc_reg <= '0;
            res_reg <= 10'd128;
        end else begin
            sma_reg <= sma_next;
            ecc_reg <= ecc_next;
            inc_reg <= inc_next;
            res_reg <= res_next;
        end
    end

    // terms that follow the configuration only
    logic [31:0]        e2_reg;
    logic [52:0]        num_reg;
    logic [15:0]        tilt_reg;
    logic signed [23:0] tilt_v;
    logic [46:0]        tilt_prod;

    assign tilt_v    = (24'(inc_reg) <<< 5) + 24'sd2949142;
    assign tilt_prod = tilt_v[22:0] * 24'd11930465;

    always_ff @(posedge aclk) begin
        e2_reg   <= ecc_reg * ecc_reg;
        num_reg  <= sma_reg * (33'h1_0000_0000 - {1'b0, e2_reg});
        tilt_reg <= tilt_prod[44:29];
    end

    // row control
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] flg_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            flg_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            flg_reg <= {flg_reg[LAT-2:0], s_tvalid && (s_tdata[9:0] == res_reg)};
        end
    end

    // phase divider: (index * 65536 + res/2) / res
    logic [9:0]  d1_rem [D1_STEPS+1];
    logic [20:0] d1_low [D1_STEPS+1];
    logic [15:0] d1_quo [D1_STEPS+1];
    logic [9:0]  d1_dvs [D1_STEPS+1];
    logic [25:0] phase_num;

    assign phase_num = {s_tdata[9:0], 16'd0} + {17'd0, res_reg[9:1]};

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_rem[0] <= {5'd0, phase_num[25:21]};
            d1_low[0] <= phase_num[20:0];
            d1_quo[0] <= '0;
            d1_dvs[0] <= res_reg;
        end
    end

    for (genvar k = 0; k < D1_STEPS; k++) begin : g_d1
        oepg_div_cell #(.DW(10), .LW(21), .QW(16)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rem_in (d1_rem[k]),
            .low_in (d1_low[k]),
            .quo_in (d1_quo[k]),
            .dvs_in (d1_dvs[k]),
            .rem_out(d1_rem[k+1]),
            .low_out(d1_low[k+1]),
            .quo_out(d1_quo[k+1]),
            .dvs_out(d1_dvs[k+1])
        );
    end

    // sine and cosine rows, orbit phase and tilt side by side
    cordic_t orb_row [CORDIC_STEPS+1];
    cordic_t tlt_row [CORDIC_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            orb_row[0] <= cordic_prep(d1_quo[D1_STEPS]);
            tlt_row[0] <= cordic_prep(tilt_reg);
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        oepg_cordic_cell #(.STEP(k)) u_orb (
            .aclk(aclk),
            .en  (en),
            .din (orb_row[k]),
            .dout(orb_row[k+1])
        );
        oepg_cordic_cell #(.STEP(k)) u_tlt (
            .aclk(aclk),
            .en  (en),
            .din (tlt_row[k]),
            .dout(tlt_row[k+1])
        );
    end

    cs_t orb_cs_reg;
    cs_t tlt_cs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            orb_cs_reg <= cordic_post(orb_row[CORDIC_STEPS]);
            tlt_cs_reg <= cordic_post(tlt_row[CORDIC_STEPS]);
        end
    end

    // radius: (num * 256 + den/2) / den, den = 2^32 + e*cos
    logic [33:0]        den_reg;
    logic signed [34:0] ecos;
    logic [60:0]        rad_num;
    cs_t                cs_dly_reg [CS_DLY];

    assign ecos    = $signed({1'b0, ecc_reg}) * orb_cs_reg.c;
    assign rad_num = {num_reg, 8'd0} + {27'd0, den_reg[33:1]};

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg       <= 34'(35'sh1_0000_0000 + ecos);
            cs_dly_reg[0] <= orb_cs_reg;
            for (int i = 1; i < CS_DLY; i++) begin
                cs_dly_reg[i] <= cs_dly_reg[i-1];
            end
        end
    end

    logic [33:0] d2_rem [D2_STEPS+1];
    logic [28:0] d2_low [D2_STEPS+1];
    logic [28:0] d2_quo [D2_STEPS+1];
    logic [33:0] d2_dvs [D2_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_rem[0] <= {2'd0, rad_num[60:29]};
            d2_low[0] <= rad_num[28:0];
            d2_quo[0] <= '0;
            d2_dvs[0] <= den_reg;
        end
    end

    for (genvar k = 0; k < D2_STEPS; k++) begin : g_d2
        oepg_div_cell #(.DW(34), .LW(29), .QW(29)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rem_in (d2_rem[k]),
            .low_in (d2_low[k]),
            .quo_in (d2_quo[k]),
            .dvs_in (d2_dvs[k]),
            .rem_out(d2_rem[k+1]),
            .low_out(d2_low[k+1]),
            .quo_out(d2_quo[k+1]),
            .dvs_out(d2_dvs[k+1])
        );
    end

    // in-plane point, then rotation about x in split partial products
    logic signed [47:0] x32_reg;
    logic signed [47:0] y32_reg;
    logic signed [47:0] x_rnd;
    logic [21:0]        x_sat_reg;
    logic signed [42:0] yh_c_reg, yh_s_reg;
    logic signed [41:0] yl_c_reg, yl_s_reg;
    logic signed [66:0] y_sum, z_sum;
    logic [21:0]        pos_x_reg, pos_y_reg, pos_z_reg;

    assign x_rnd = (x32_reg + 48'sd8388608) >>> 24;
    assign y_sum = ((67'(yh_c_reg) <<< 23) + 67'(yl_c_reg) + (67'sd1 <<< 39)) >>> 40;
    assign z_sum = ((67'(yh_s_reg) <<< 23) + 67'(yl_s_reg) + (67'sd1 <<< 39)) >>> 40;

    always_ff @(posedge aclk) begin
        if (en) begin
            x32_reg   <= $signed({1'b0, d2_quo[D2_STEPS]}) * cs_dly_reg[CS_DLY-1].c;
            y32_reg   <= $signed({1'b0, d2_quo[D2_STEPS]}) * cs_dly_reg[CS_DLY-1].s;
            x_sat_reg <= sat_out(67'(x_rnd));
            yh_c_reg  <= $signed(y32_reg[47:23]) * tlt_cs_reg.c;
            yh_s_reg  <= $signed(y32_reg[47:23]) * tlt_cs_reg.s;
            yl_c_reg  <= $signed({1'b0, y32_reg[22:0]}) * tlt_cs_reg.c;
            yl_s_reg  <= $signed({1'b0, y32_reg[22:0]}) * tlt_cs_reg.s;
            pos_x_reg <= x_sat_reg;
            pos_y_reg <= sat_out(y_sum);
            pos_z_reg <= sat_out(z_sum);
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tlast  = flg_reg[LAT-1];
    assign m_tdata  = {6'd0, pos_z_reg, pos_y_reg, pos_x_reg};

    a_tlast_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast |-> m_tvalid)
        else $error("closing flag without a transaction");

    a_ecc_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        ecc_reg <= ECC_MAX)
        else $error("eccentricity above clamp");

    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_reg >= RES_MIN && 32'(res_reg) <= MAX_RESOLUTION)
        else $error("resolution out of range");

endmodule
